/* rtl/core/frka_pkg.sv */
// shared types and codes for the recycling key allocator
// no dependencies; imported by all rtl/core modules

package frka_pkg;

    localparam int KEY_W  = 16;
    localparam int WIDE_W = KEY_W + 1;

    localparam logic [KEY_W-1:0] INVALID_KEY = '0;

    // request operation codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // configuration register indexes
    localparam logic REG_MIN_KEY = 1'b0;
    localparam logic REG_MAX_KEY = 1'b1;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_EXHAUSTED    = 2'd1,
        ST_DOUBLE_FREE  = 2'd2,
        ST_OUT_OF_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

    // min <= k <= max and k - min below the span
    function automatic logic key_in_range(
        input logic [WIDE_W-1:0] k,
        input logic [KEY_W-1:0]  mn,
        input logic [KEY_W-1:0]  mx,
        input logic [WIDE_W-1:0] span
    );
        logic [WIDE_W-1:0] diff;
        diff = k - {1'b0, mn};
        return (k >= {1'b0, mn}) && (k <= {1'b0, mx}) && (diff < span);
    endfunction

endpackage

/* rtl/core/frka_key_fifo.sv */
// ring buffer of returned keys with head, tail and fill count
// depends on frka_pkg

module frka_key_fifo
    import frka_pkg::*;
#(
    parameter int KEY_SPAN = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop,
    output logic [KEY_W-1:0] pop_key,
    input  logic             push,
    input  logic [KEY_W-1:0] push_key,
    output fifo_stat_t       stat
);

    localparam int PTR_W = $clog2(KEY_SPAN);
    localparam int CNT_W = $clog2(KEY_SPAN + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(KEY_SPAN - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(KEY_SPAN);

    logic [KEY_W-1:0] mem [KEY_SPAN];
    logic [KEY_W-1:0] rd_data_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop)
        begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
        end
        if (push)
        begin
            tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
        end
        if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
        else if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= push_key;
        end
        if (pop)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    assign pop_key    = rd_data_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_FULL);

endmodule

/* rtl/core/frka_mark_mem.sv */
// returned-mark bitmap indexed by key offset, swept to zero after reset
// depends on frka_pkg

module frka_mark_mem
    import frka_pkg::*;
#(
    parameter int KEY_SPAN = 1024
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [$clog2(KEY_SPAN)-1:0] rd_addr,
    output logic                        rd_bit,
    input  logic                        wr_en,
    input  logic [$clog2(KEY_SPAN)-1:0] wr_addr,
    input  logic                        wr_bit,
    output logic                        busy
);

    localparam int OFF_W = $clog2(KEY_SPAN);
    localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(KEY_SPAN - 1);

    logic             mem [KEY_SPAN];
    logic             rd_bit_reg;
    logic             busy_reg, busy_next;
    logic [OFF_W-1:0] clr_ptr_reg, clr_ptr_next;

    always_comb
    begin
        busy_next    = busy_reg;
        clr_ptr_next = clr_ptr_reg;
        if (busy_reg)
        begin
            clr_ptr_next = clr_ptr_reg + 1'b1;
            if (clr_ptr_reg == OFF_LAST)
            begin
                busy_next    = 1'b0;
                clr_ptr_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_ptr_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            clr_ptr_reg <= clr_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_ptr_reg] <= 1'b0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_bit;
        end
        if (rd_en)
        begin
            rd_bit_reg <= mem[rd_addr];
        end
    end

    assign rd_bit = rd_bit_reg;
    assign busy   = busy_reg;

endmodule

/* rtl/core/fifo_recycling_key_allocator.sv */
// recycling key allocator: reuses returned keys oldest first, else issues fresh keys
// result: the request is held in S_EXEC, then out_key and status are registered
// in_stall holds new requests until the held one completes and is written back
// reset: the mark bitmap is swept to zero, in_stall held high meanwhile
// depends on frka_pkg, frka_key_fifo, frka_mark_mem

module fifo_recycling_key_allocator
    import frka_pkg::*;
#(
    parameter int KEY_SPAN = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             func,
    input  logic [KEY_W-1:0] free_key,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [KEY_W-1:0] out_key,
    output logic [1:0]       status,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [KEY_W-1:0] cfg_data
);

    localparam int OFF_W = $clog2(KEY_SPAN);
    localparam logic [WIDE_W-1:0] SPAN_W = WIDE_W'(KEY_SPAN);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t            state_reg, state_next;
    logic [KEY_W-1:0]  min_key_reg, min_key_next;
    logic [KEY_W-1:0]  max_key_reg, max_key_next;
    logic [WIDE_W-1:0] fresh_reg, fresh_next;
    logic              func_reg, func_next;
    logic [KEY_W-1:0]  free_key_reg, free_key_next;
    logic              free_ok_reg, free_ok_next;
    logic              popped_reg, popped_next;
    logic              out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]  out_key_reg, out_key_next;
    status_t           status_reg, status_next;

    logic              accept;
    logic              done;
    logic              mark_busy;
    logic              mark_rd_bit;
    logic              mark_we;
    logic              mark_wbit;
    logic [OFF_W-1:0]  mark_waddr;
    logic [KEY_W-1:0]  in_diff;
    logic [KEY_W-1:0]  held_diff;
    logic [KEY_W-1:0]  pop_diff;
    logic              fifo_pop;
    logic              fifo_push;
    logic [KEY_W-1:0]  pop_key;
    fifo_stat_t        fstat;
    logic              fresh_inc;
    logic [KEY_W-1:0]  res_key;
    status_t           res_status;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || mark_busy;
    assign done     = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    assign in_diff   = free_key - min_key_reg;
    assign held_diff = free_key_reg - min_key_reg;
    assign pop_diff  = pop_key - min_key_reg;
    assign fifo_pop  = accept && (func == FUNC_ALLOC) && !fstat.empty;

    frka_key_fifo #(.KEY_SPAN(KEY_SPAN)) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop      (fifo_pop),
        .pop_key  (pop_key),
        .push     (fifo_push),
        .push_key (free_key_reg),
        .stat     (fstat)
    );

    frka_mark_mem #(.KEY_SPAN(KEY_SPAN)) u_mark (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && (func == FUNC_FREE)),
        .rd_addr (in_diff[OFF_W-1:0]),
        .rd_bit  (mark_rd_bit),
        .wr_en   (mark_we),
        .wr_addr (mark_waddr),
        .wr_bit  (mark_wbit),
        .busy    (mark_busy)
    );

    // result and write-back for the held request
    always_comb
    begin
        res_key    = INVALID_KEY;
        res_status = ST_OK;
        fifo_push  = 1'b0;
        mark_we    = 1'b0;
        mark_wbit  = 1'b0;
        mark_waddr = held_diff[OFF_W-1:0];
        fresh_inc  = 1'b0;
        if (func_reg == FUNC_ALLOC)
        begin
            if (popped_reg)
            begin
                res_key    = pop_key;
                mark_waddr = pop_diff[OFF_W-1:0];
                // stale keys outside the range leave the marks alone
                mark_we    = done && key_in_range({1'b0, pop_key}, min_key_reg,
                                                  max_key_reg, SPAN_W);
            end
            else if (key_in_range(fresh_reg, min_key_reg, max_key_reg, SPAN_W))
            begin
                res_key   = fresh_reg[KEY_W-1:0];
                fresh_inc = done;
            end
            else
            begin
                res_status = ST_EXHAUSTED;
            end
        end
        else
        begin
            if (!free_ok_reg)
            begin
                res_status = ST_OUT_OF_RANGE;
            end
            else if (mark_rd_bit)
            begin
                res_status = ST_DOUBLE_FREE;
            end
            else if (fstat.full)
            begin
                res_status = ST_EXHAUSTED;
            end
            else
            begin
                fifo_push = done;
                mark_we   = done;
                mark_wbit = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        min_key_next   = min_key_reg;
        max_key_next   = max_key_reg;
        fresh_next     = fresh_reg;
        func_next      = func_reg;
        free_key_next  = free_key_reg;
        free_ok_next   = free_ok_reg;
        popped_next    = popped_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_key_next   = out_key_reg;
        status_next    = status_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_KEY:
                begin
                    min_key_next = cfg_data;
                    fresh_next   = {1'b0, cfg_data};
                end
                REG_MAX_KEY: max_key_next = cfg_data;
                default: max_key_next = max_key_reg;
            endcase
        end
        else if (fresh_inc)
        begin
            fresh_next = fresh_reg + 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next     = func;
                    free_key_next = free_key;
                    free_ok_next  = key_in_range({1'b0, free_key}, min_key_reg,
                                                 max_key_reg, SPAN_W);
                    popped_next   = fifo_pop;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (done)
                begin
                    out_valid_next = 1'b1;
                    out_key_next   = res_key;
                    status_next    = res_status;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            min_key_reg   <= 16'd1;
            max_key_reg   <= 16'd1024;
            fresh_reg     <= 17'd1;
            out_valid_reg <= 1'b0;
            out_key_reg   <= INVALID_KEY;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            min_key_reg   <= min_key_next;
            max_key_reg   <= max_key_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
            out_key_reg   <= out_key_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        free_key_reg <= free_key_next;
        free_ok_reg  <= free_ok_next;
        popped_reg   <= popped_next;
    end

    assign out_valid = out_valid_reg;
    assign out_key   = out_key_reg;
    assign status    = status_reg;

endmodule
